// ===== rtl/htach_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htach_pkg: shared types and constants
// field widths, register indexes and arithmetic constants of the tachometer
// ----------------------------------------------------------------------------
package htach_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned SpeedW  = 13;
  localparam int unsigned AccelW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 12;

  // dividend width of the shared divider (60000000 fits in 26 bits)
  localparam int unsigned DvdW    = 26;
  // multiplier constant width and product width
  localparam int unsigned KW      = 17;
  localparam int unsigned MulAccW = 33;
  localparam int unsigned SpeedLsb = 20;

  localparam logic [DvdW-1:0]    RpmNum = 26'd60000000;
  localparam logic [RpmW-1:0]    RpmMax = 16'hFFFF;
  localparam logic [KW-1:0]      SpeedK = 17'd109807;
  localparam logic [SampleW-1:0] HighLevelRst = 12'd3700;
  localparam logic [SampleW-1:0] LowLevelRst  = 12'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHighLevel = 2'd0,
    CfgLowLevel  = 2'd1,
    CfgInverted  = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/htach_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htach_in_if: sensor sample channel
// valid/ready channel carrying one sample and its timestamp
// ----------------------------------------------------------------------------
interface htach_in_if import htach_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic [TimeW-1:0]   timestamp_us;

  modport source (output valid, sample, timestamp_us, input ready);
  modport sink   (input valid, sample, timestamp_us, output ready);
endinterface

// ===== rtl/htach_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htach_out_if: revolution result channel
// valid/ready channel carrying period, rpm, speed and acceleration
// ----------------------------------------------------------------------------
interface htach_out_if import htach_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TimeW-1:0]         period_us;
  logic [RpmW-1:0]          rpm;
  logic [SpeedW-1:0]        speed_rad;
  logic signed [AccelW-1:0] ang_accel;

  modport source (output valid, period_us, rpm, speed_rad, ang_accel, input ready);
  modport sink   (input valid, period_us, rpm, speed_rad, ang_accel, output ready);
endinterface

// ===== rtl/hysteresis_tachometer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysteresis_tachometer: one-mark-per-revolution optical tachometer
// hysteresis mark detection, bit-serial period-to-rpm divide, speed multiply
// and acceleration divide
// ----------------------------------------------------------------------------
// while idle the block takes one transfer per cycle; a sample that does
//   not fire keeps it idle, a firing sample makes it busy through the
//   shift-subtract divider (rpm), the shift-add multiplier (speed), the
//   same divider again (acceleration) and the output register load
// input is ready again in the cycle the result shows; the output register
//   holds it while the next samples are taken
// reset: thresholds 3700 / 2000, normal polarity, disarmed, last fire time
//   and previous speed zero, no result pending
// ----------------------------------------------------------------------------
module hysteresis_tachometer import htach_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  htach_in_if.sink           in_i,
  htach_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  typedef enum logic [2:0] {
    StIdle,
    StDivRpm,
    StMul,
    StDivAcc,
    StDone
  } state_e;

  // configuration registers
  logic [SampleW-1:0] high_q, low_q;
  logic               inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= HighLevelRst;
      low_q  <= LowLevelRst;
      inv_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHighLevel: high_q <= cfg_wdata_i[SampleW-1:0];
        CfgLowLevel:  low_q  <= cfg_wdata_i[SampleW-1:0];
        CfgInverted:  inv_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  state_e                   state_q, state_d;
  logic                     armed_q, armed_d;
  logic [TimeW-1:0]         last_fire_q, last_fire_d;
  logic [SpeedW-1:0]        prev_speed_q, prev_speed_d;
  logic [TimeW-1:0]         period_q, period_d;
  // shared divider: partial remainder, dividend shift line, quotient
  logic [TimeW-1:0]         rem_q, rem_d;
  logic [DvdW-1:0]          dvd_q, dvd_d;
  logic [DvdW-1:0]          quo_q, quo_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  // shift-add multiplier: product accumulator and multiplier shift line
  logic [MulAccW-1:0]       acc_q, acc_d;
  logic [RpmW-1:0]          mul_sr_q, mul_sr_d;
  logic [RpmW-1:0]          rpm_q, rpm_d;
  logic [SpeedW-1:0]        speed_q, speed_d;
  logic                     neg_q, neg_d;
  // output register
  logic                     out_valid_q, out_valid_d;
  logic [TimeW-1:0]         out_period_q, out_period_d;
  logic [RpmW-1:0]          out_rpm_q, out_rpm_d;
  logic [SpeedW-1:0]        out_speed_q, out_speed_d;
  logic signed [AccelW-1:0] out_accel_q, out_accel_d;

  logic                     above, below, fire_cond, arm_cond;
  logic                     in_xfer, out_xfer;
  logic [TimeW:0]           rem_sh;
  logic                     div_ge;
  logic [TimeW:0]           rem_sub;
  logic [DvdW-1:0]          quo_nx;
  logic [RpmW-1:0]          rpm_sat;
  logic [MulAccW-RpmW:0]    mul_sum;
  logic [MulAccW-1:0]       acc_nx;
  logic [SpeedW-1:0]        speed_nx;
  logic                     neg_nx;
  logic [SpeedW-1:0]        mag;
  logic [AccelW-1:0]        accel_mag;

  // hysteresis compare; polarity swaps arm and fire
  assign above     = in_i.sample > high_q;
  assign below     = in_i.sample < low_q;
  assign fire_cond = inv_q ? below : above;
  assign arm_cond  = inv_q ? above : below;

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;

  // one restoring division step, one quotient bit per cycle
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign div_ge  = rem_sh >= {1'b0, period_q};
  assign rem_sub = rem_sh - {1'b0, period_q};
  assign quo_nx  = {quo_q[DvdW-2:0], div_ge};
  assign rpm_sat = (|quo_nx[DvdW-1:RpmW]) ? RpmMax : quo_nx[RpmW-1:0];

  // one shift-add multiply step, lsb of rpm first
  assign mul_sum = {1'b0, acc_q[MulAccW-1:RpmW]}
                 + (mul_sr_q[0] ? {1'b0, SpeedK} : '0);
  assign acc_nx   = {mul_sum, acc_q[RpmW-1:1]};
  assign speed_nx = acc_nx[SpeedLsb +: SpeedW];
  assign neg_nx   = speed_nx < prev_speed_q;
  assign mag      = neg_nx ? (prev_speed_q - speed_nx) : (speed_nx - prev_speed_q);
  // finished acceleration quotient, held while the result waits to load
  assign accel_mag = {{(AccelW-SpeedW){1'b0}}, quo_q[SpeedW-1:0]};

  always_comb begin
    state_d      = state_q;
    armed_d      = armed_q;
    last_fire_d  = last_fire_q;
    prev_speed_d = prev_speed_q;
    period_d     = period_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    mul_sr_d     = mul_sr_q;
    rpm_d        = rpm_q;
    speed_d      = speed_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q && !out_xfer;
    out_period_d = out_period_q;
    out_rpm_d    = out_rpm_q;
    out_speed_d  = out_speed_q;
    out_accel_d  = out_accel_q;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          // fire test first, then the arm test on the same sample
          armed_d = arm_cond || (armed_q && !fire_cond);
          if (fire_cond && armed_q) begin
            period_d    = in_i.timestamp_us - last_fire_q;
            last_fire_d = in_i.timestamp_us;
            dvd_d       = RpmNum;
            rem_d       = '0;
            quo_d       = '0;
            cnt_d       = CntW'(DvdW - 1);
            state_d     = StDivRpm;
          end
        end
      end
      StDivRpm: begin
        rem_d = div_ge ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
        quo_d = quo_nx;
        if (cnt_q == '0) begin
          // zero period gives an all-ones quotient, which saturates
          rpm_d    = rpm_sat;
          mul_sr_d = rpm_sat;
          acc_d    = '0;
          cnt_d    = CntW'(RpmW - 1);
          state_d  = StMul;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StMul: begin
        acc_d    = acc_nx;
        mul_sr_d = {1'b0, mul_sr_q[RpmW-1:1]};
        if (cnt_q == '0) begin
          speed_d = speed_nx;
          neg_d   = neg_nx;
          // magnitude in the top bits of the dividend line
          dvd_d   = {mag, {(DvdW-SpeedW){1'b0}}};
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = CntW'(SpeedW - 1);
          state_d = StDivAcc;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDivAcc: begin
        rem_d = div_ge ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
        quo_d = quo_nx;
        if (cnt_q == '0) begin
          prev_speed_d = speed_q;
          state_d      = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        // load the output register once it is free
        if (!out_valid_q || out_xfer) begin
          out_valid_d  = 1'b1;
          out_period_d = period_q;
          out_rpm_d    = rpm_q;
          out_speed_d  = speed_q;
          if (period_q == '0) begin
            out_accel_d = '0;
          end else if (neg_q) begin
            out_accel_d = $signed(AccelW'(0) - accel_mag);
          end else begin
            out_accel_d = $signed(accel_mag);
          end
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      armed_q      <= 1'b0;
      last_fire_q  <= '0;
      prev_speed_q <= '0;
      period_q     <= '0;
      rem_q        <= '0;
      dvd_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      acc_q        <= '0;
      mul_sr_q     <= '0;
      rpm_q        <= '0;
      speed_q      <= '0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_period_q <= '0;
      out_rpm_q    <= '0;
      out_speed_q  <= '0;
      out_accel_q  <= '0;
    end else begin
      state_q      <= state_d;
      armed_q      <= armed_d;
      last_fire_q  <= last_fire_d;
      prev_speed_q <= prev_speed_d;
      period_q     <= period_d;
      rem_q        <= rem_d;
      dvd_q        <= dvd_d;
      quo_q        <= quo_d;
      cnt_q        <= cnt_d;
      acc_q        <= acc_d;
      mul_sr_q     <= mul_sr_d;
      rpm_q        <= rpm_d;
      speed_q      <= speed_d;
      neg_q        <= neg_d;
      out_valid_q  <= out_valid_d;
      out_period_q <= out_period_d;
      out_rpm_q    <= out_rpm_d;
      out_speed_q  <= out_speed_d;
      out_accel_q  <= out_accel_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.period_us = out_period_q;
  assign out_o.rpm       = out_rpm_q;
  assign out_o.speed_rad = out_speed_q;
  assign out_o.ang_accel = out_accel_q;

  // a firing transfer makes the block busy in the next cycle
  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && fire_cond && armed_q) |=> !in_i.ready)
    else $error("firing sample did not start the arithmetic");

  // zero period saturates rpm and gives zero acceleration
  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.period_us == '0) |->
      (out_o.rpm == RpmMax && out_o.ang_accel == '0))
    else $error("zero period result is wrong");

  // speed never exceeds the value for saturated rpm
  a_speed_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.speed_rad <= SpeedW'(6862))
    else $error("speed out of range");

  // step counter stays within the longest pass
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DvdW - 1))
    else $error("step counter out of range");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hysteresis_tachometer
// drives sensor samples over the input channel, predicts revolution results
// with a local model of the mark detector and the period, rpm, speed
// and acceleration arithmetic, and compares each output transfer field by
// field; a short table of directed rows runs first, then random phases
// under several threshold settings and handshake idling regimes
// ----------------------------------------------------------------------------
module tb;
  import htach_pkg::*;

  // unused register index, writes there must change nothing
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;
  // cycles to let a firing sample finish after the last result showed up
  localparam int unsigned SettleCycles = 100;

  typedef struct packed {
    logic [TimeW-1:0]         period_us;
    logic [RpmW-1:0]          rpm;
    logic [SpeedW-1:0]        speed_rad;
    logic signed [AccelW-1:0] ang_accel;
  } rev_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  // one line of the directed plan: a sample transfer or a register write;
  // given rows carry a hand-written result (or none), the rest use the model
  typedef struct packed {
    row_kind_e          kind;
    logic [SampleW-1:0] sample;
    logic [TimeW-1:0]   ts;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    wdata;
    logic               given;
    logic               fires;
    rev_t               rev;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  htach_in_if  in_if ();
  htach_out_if out_if ();

  hysteresis_tachometer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // --------------------------------------------------------------------------
  // local copy of the detector: thresholds, polarity and revolution state
  // --------------------------------------------------------------------------
  logic [SampleW-1:0] thr_high;
  logic [SampleW-1:0] thr_low;
  logic               polarity_inv;
  logic               det_armed;
  logic [TimeW-1:0]   last_mark_ts;
  logic [SpeedW-1:0]  last_speed;

  rev_t rev_q [$];       // revolutions predicted but not yet seen at the output
  int   mismatches;
  int   src_idle_pct;    // chance in percent that the sender idles a cycle
  int   snk_stall_pct;   // chance in percent that the receiver stalls a cycle
  int   rand_sent;       // random-phase samples transferred so far

  // hysteresis step for one sample; returns 1 when the mark fires
  function automatic bit mark_revolution(input logic [SampleW-1:0] s,
                                         input logic [TimeW-1:0] ts,
                                         output rev_t r);
    logic              above;
    logic              below;
    logic              fire_c;
    logic              arm_c;
    logic [TimeW-1:0]  period;
    logic [31:0]       rpm32;
    logic [63:0]       prod;
    logic [SpeedW-1:0] spd;
    logic [31:0]       mag;
    bit                fired;
    above  = s > thr_high;
    below  = s < thr_low;
    fire_c = polarity_inv ? below : above;
    arm_c  = polarity_inv ? above : below;
    fired  = 1'b0;
    r      = '0;
    // fire test first, arm test after it on the same sample
    if (fire_c && det_armed) begin
      period = ts - last_mark_ts;  // wraps modulo 2^32
      if (period == '0) begin
        rpm32 = 32'(RpmMax);
      end else begin
        rpm32 = 32'(RpmNum) / period;
        if (rpm32 > 32'(RpmMax)) rpm32 = 32'(RpmMax);
      end
      // 20 fraction bits, truncated
      prod = 64'(rpm32) * 64'(SpeedK);
      spd  = prod[SpeedLsb +: SpeedW];
      mag  = (spd < last_speed) ? 32'(last_speed - spd) : 32'(spd - last_speed);
      // zero period gives no acceleration
      mag  = (period == '0) ? 32'd0 : mag / period;
      r.period_us = period;
      r.rpm       = rpm32[RpmW-1:0];
      r.speed_rad = spd;
      r.ang_accel = (spd < last_speed) ? -mag[AccelW-1:0] : mag[AccelW-1:0];
      last_speed   = spd;
      last_mark_ts = ts;
      det_armed    = 1'b0;
      fired        = 1'b1;
    end
    if (arm_c) det_armed = 1'b1;
    return fired;
  endfunction

  // --------------------------------------------------------------------------
  // plan row builders
  // --------------------------------------------------------------------------
  function automatic plan_row_t smp(input logic [SampleW-1:0] s, input logic [TimeW-1:0] ts);
    plan_row_t row;
    row        = '0;
    row.kind   = RowSample;
    row.sample = s;
    row.ts     = ts;
    return row;
  endfunction

  // sample whose outcome is plainly no result
  function automatic plan_row_t smp_none(input logic [SampleW-1:0] s,
                                         input logic [TimeW-1:0] ts);
    plan_row_t row;
    row       = smp(s, ts);
    row.given = 1'b1;
    return row;
  endfunction

  // sample with a hand-written result
  function automatic plan_row_t smp_rev(input logic [SampleW-1:0] s, input logic [TimeW-1:0] ts,
                                        input logic [TimeW-1:0] p, input logic [RpmW-1:0] rpm,
                                        input logic [SpeedW-1:0] spd,
                                        input logic signed [AccelW-1:0] acc);
    plan_row_t row;
    row               = smp(s, ts);
    row.given         = 1'b1;
    row.fires         = 1'b1;
    row.rev.period_us = p;
    row.rev.rpm       = rpm;
    row.rev.speed_rad = spd;
    row.rev.ang_accel = acc;
    return row;
  endfunction

  function automatic plan_row_t wr(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] d);
    plan_row_t row;
    row         = '0;
    row.kind    = RowWrite;
    row.reg_idx = idx;
    row.wdata   = d;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // random sample pickers, biased toward the threshold edges
  // --------------------------------------------------------------------------
  function automatic logic [SampleW-1:0] pick_above();
    if (thr_high == '1) return SampleW'($urandom_range(4095));
    if ($urandom_range(3) == 0) return thr_high + 1'b1;
    return SampleW'($urandom_range(32'(thr_high) + 1, 4095));
  endfunction

  function automatic logic [SampleW-1:0] pick_below();
    if (thr_low == '0) return SampleW'($urandom_range(4095));
    if ($urandom_range(3) == 0) return thr_low - 1'b1;
    return SampleW'($urandom_range(0, 32'(thr_low) - 1));
  endfunction

  // a sample that neither arms nor fires, where such a sample exists
  function automatic logic [SampleW-1:0] pick_mid();
    if (thr_low > thr_high) return SampleW'($urandom_range(4095));
    return SampleW'($urandom_range(32'(thr_low), 32'(thr_high)));
  endfunction

  // revolution period, spread over saturation, the useful rpm range and wrap
  function automatic logic [TimeW-1:0] pick_period();
    int sh;
    sh = $urandom_range(13, 26);
    case ($urandom_range(9))
      0:       return TimeW'($urandom_range(3));
      1:       return TimeW'($urandom_range(916));
      2, 3:    return TimeW'($urandom_range(900, 10000));
      8:       return $urandom;
      9:       return TimeW'($urandom_range(30000000, 70000000));
      default: return TimeW'($urandom_range(1 << (sh - 1), 1 << sh));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset and time limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // well past the slowest correct run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls and the result check
  // --------------------------------------------------------------------------
  task automatic chk(input string field, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    rev_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rev_q.size() == 0) begin
        $error("period_us: expected no transfer, got %0d", out_if.period_us);
        mismatches++;
      end else begin
        want = rev_q.pop_front();
        chk("period_us", want.period_us, out_if.period_us);
        chk("rpm", want.rpm, out_if.rpm);
        chk("speed_rad", want.speed_rad, out_if.speed_rad);
        chk("ang_accel", want.ang_accel, out_if.ang_accel);
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  // one sample transfer; prediction happens once ready is seen high after an edge
  task automatic send(input plan_row_t row);
    rev_t r;
    bit   fired;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample       <= row.sample;
    in_if.timestamp_us <= row.ts;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    fired = mark_revolution(row.sample, row.ts, r);
    if (row.given) begin
      if (row.fires) rev_q.push_back(row.rev);
    end else if (fired) begin
      rev_q.push_back(r);
    end
  endtask

  // hold off until every predicted result is out, then let a late firing
  // sample finish as well
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (rev_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] d);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgHighLevel: thr_high     = d[SampleW-1:0];
      CfgLowLevel:  thr_low      = d[SampleW-1:0];
      CfgInverted:  polarity_inv = d[0];
      default: ;
    endcase
  endtask

  // random-phase transfer; the idling regime follows the running count:
  // slow receiver first, then slow sender, then no idling
  task automatic feed(input logic [SampleW-1:0] s, input logic [TimeW-1:0] ts);
    if (rand_sent < 317) begin
      src_idle_pct  = 18;
      snk_stall_pct = 71;
    end else if (rand_sent < 634) begin
      src_idle_pct  = 71;
      snk_stall_pct = 18;
    end else begin
      src_idle_pct  = 0;
      snk_stall_pct = 0;
    end
    send(smp(s, ts));
    rand_sent++;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  plan_row_t plan [$];

  initial begin
    logic [TimeW-1:0]   t_now;
    logic [TimeW-1:0]   p;
    logic [SampleW-1:0] h;
    logic [SampleW-1:0] l;
    logic               v;
    int                 quota;
    int                 r;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgHighLevel;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.sample       <= '0;
    in_if.timestamp_us <= '0;

    // reset state of the block
    thr_high      = HighLevelRst;
    thr_low       = LowLevelRst;
    polarity_inv  = 1'b0;
    det_armed     = 1'b0;
    last_mark_ts  = '0;
    last_speed    = '0;
    mismatches    = 0;
    rand_sent     = 0;
    src_idle_pct  = 18;
    snk_stall_pct = 71;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed plan, reset thresholds 3700 / 2000 in force at the start
    // first firing after reset measures from time zero: zero period
    plan.push_back(smp_none(12'd0, 32'd0));
    plan.push_back(smp_rev(12'd4095, 32'd0, 32'd0, 16'd65535, 13'd6862, 16'sd0));
    // thresholds are strict: equal to high or low does nothing
    plan.push_back(smp_none(12'd1999, 32'd3));
    plan.push_back(smp_none(12'd3700, 32'd4));
    plan.push_back(smp_none(12'd2000, 32'd4));
    plan.push_back(smp_rev(12'd3701, 32'd5, 32'd5, 16'd65535, 13'd6862, 16'sd0));
    // timestamp going back one: period wraps to all ones
    plan.push_back(smp_none(12'd0, 32'd5));
    plan.push_back(smp_rev(12'd4095, 32'd4, 32'hFFFF_FFFF, 16'd0, 13'd0, 16'sd0));
    // exactly one rpm
    plan.push_back(smp_none(12'd0, 32'd100));
    plan.push_back(smp_rev(12'd4095, 32'd60000004, 32'd60000000, 16'd1, 13'd0, 16'sd0));
    // fast revolution then a slower one: positive then negative acceleration
    plan.push_back(smp(12'd1000, 32'd60000100));
    plan.push_back(smp(12'd3800, 32'd60001004));
    plan.push_back(smp(12'd5, 32'd60002000));
    plan.push_back(smp(12'd4000, 32'd60006004));
    // inverted polarity: arm above high, fire below low
    plan.push_back(wr(CfgInverted, 12'd1));
    plan.push_back(smp(12'd4095, 32'd60010000));
    plan.push_back(smp(12'd0, 32'd60010916));
    // overlapping thresholds: one sample fires and re-arms
    plan.push_back(wr(CfgHighLevel, 12'd100));
    plan.push_back(wr(CfgLowLevel, 12'd200));
    plan.push_back(smp(12'd150, 32'd60011000));
    plan.push_back(smp(12'd150, 32'd60011001));
    // only bit 0 of the polarity write counts
    plan.push_back(wr(CfgInverted, 12'hABC));
    plan.push_back(smp(12'd150, 32'd60011002));
    // write to the unused index changes nothing
    plan.push_back(wr(CfgNoReg, 12'hFFF));
    plan.push_back(smp(12'd150, 32'd60011010));

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) write_reg(plan[i].reg_idx, plan[i].wdata);
      else send(plan[i]);
    end

    // random phases, each under its own threshold setting
    t_now = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      quota = 135;
      case (ph)
        0: begin
          h = HighLevelRst;
          l = LowLevelRst;
          v = 1'b0;
        end
        1, 2: begin
          h = SampleW'($urandom_range(2048, 4095));
          l = SampleW'($urandom_range(0, 2047));
          v = (ph == 2);
        end
        3, 4: begin
          // low above high: overlap band fires and re-arms
          h = SampleW'($urandom_range(0, 3000));
          l = SampleW'($urandom_range(32'(h) + 1, 4095));
          v = (ph == 4);
        end
        5: begin
          h = '0;
          l = '1;
          v = 1'b0;
        end
        6: begin
          h     = '0;
          l     = '1;
          v     = 1'b1;
          quota = 100;
        end
        default: begin
          // nothing is ever above or below: no result can come
          h     = '1;
          l     = '0;
          v     = $urandom_range(1);
          quota = 40;
        end
      endcase
      write_reg(CfgHighLevel, h);
      write_reg(CfgLowLevel, l);
      write_reg(CfgInverted, CfgW'(v));
      quota += rand_sent;

      while (rand_sent < quota) begin
        r = $urandom_range(99);
        if (r < 10) begin
          // noise: any sample at any time
          feed(SampleW'($urandom_range(4095)), $urandom);
        end else if (r < 15) begin
          feed(pick_mid(), t_now);
        end else begin
          // one revolution: arm somewhere inside the period, fire at its end;
          // a few skip the arm or fire twice
          p = pick_period();
          if (r >= 23) begin
            feed(polarity_inv ? pick_above() : pick_below(),
                 t_now + TimeW'($urandom_range(32'(p), 0)));
          end
          if ($urandom_range(2) == 0) feed(pick_mid(), t_now + (p >> 1));
          t_now = t_now + p;
          feed(polarity_inv ? pick_below() : pick_above(), t_now);
          if (r < 19) feed(polarity_inv ? pick_below() : pick_above(),
                           t_now + TimeW'($urandom_range(50)));
        end
      end
    end

    // drain: every predicted result out, then the settle wait
    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/htach_pkg.sv
rtl/htach_in_if.sv
rtl/htach_out_if.sv
rtl/hysteresis_tachometer.sv
sim/tb.sv
